// ----- hdl/tlvrs_pkg.sv -----
`timescale 1ns / 1ps

package tlvrs_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TAG,
    PH_LEN,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_VALUE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_NONE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [15:0] value_length;
    kind_e       kind;
    logic [7:0]  out_byte;
  } result_t;

  localparam logic [7:0] LEN_ONE_BYTE  = 8'h81;
  localparam logic [7:0] LEN_TWO_BYTES = 8'h82;
  localparam logic [3:0] POS_MODE      = 4'hF;
  localparam logic [3:0] POS_NONE      = 4'h0;
  localparam logic [3:0] COUNT_MAX     = 4'hF;
  localparam logic [7:0] SCAN_INVALID  = 8'hFF;
  localparam logic [7:0] OFFSET_MAX    = 8'hFF;

  localparam int unsigned RES_DEPTH = 4;

endpackage

// ----- hdl/tlv_record_search_unit.sv -----
`timescale 1ns / 1ps

// BER-TLV record search. One byte is taken per cycle while s_axis_tready is
// high; the parser state is updated by short logic in the same cycle a request
// is accepted, and the results it causes (at most two: a value byte and a
// done/not-found marker) are written into a four-entry result queue.
// s_axis_tready is high while at least two queue slots are free, so with the
// output side taking a request every cycle the block sustains one input byte
// per cycle; the queue drain of one result per cycle is what sets the rate when
// a byte yields two results. A search starts on a byte flagged first (tuser)
// and ends with a done result carrying the value length or with a not-found
// result; bytes outside a search produce nothing.
module tlv_record_search_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // in_byte[7:0], query_tag[15:8], scan_length[23:16]
  input  logic        s_axis_tuser,   // first_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_byte[7:0], value_length[23:8]
  output logic [1:0]  m_axis_tuser    // kind
);

  localparam int unsigned PtrW = $clog2(tlvrs_pkg::RES_DEPTH);
  localparam int unsigned CntW = $clog2(tlvrs_pkg::RES_DEPTH + 1);

  tlvrs_pkg::phase_e phase_q, phase_d;
  logic [7:0]  offset_q, offset_d;
  logic [3:0]  count_q, count_d;
  logic [15:0] remain_q, remain_d;
  logic [15:0] rec_len_q, rec_len_d;
  logic        selected_q, selected_d;
  logic [7:0]  query_q, query_d;
  logic [7:0]  scan_q, scan_d;

  tlvrs_pkg::result_t res_mem_q [tlvrs_pkg::RES_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] fill_q, fill_d;

  tlvrs_pkg::result_t res0, res1;
  logic push0, push1;
  logic in_acc, out_acc;

  logic [7:0] in_byte;
  assign in_byte = s_axis_tdata[7:0];

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = fill_q <= CntW'(tlvrs_pkg::RES_DEPTH - 2);

  // parser step for one accepted byte
  always_comb begin
    logic done;
    logic emit0, emit1;
    tlvrs_pkg::result_t r0, r1;
    logic pos_mode;

    phase_d    = phase_q;
    offset_d   = offset_q;
    count_d    = count_q;
    remain_d   = remain_q;
    rec_len_d  = rec_len_q;
    selected_d = selected_q;
    query_d    = query_q;
    scan_d     = scan_q;
    done  = 1'b0;
    emit0 = 1'b0;
    emit1 = 1'b0;
    pos_mode = 1'b0;
    r0 = '{value_length: 16'd0, kind: tlvrs_pkg::KIND_NONE, out_byte: 8'd0};
    r1 = '{value_length: 16'd0, kind: tlvrs_pkg::KIND_NONE, out_byte: 8'd0};

    if (in_acc) begin
      if (s_axis_tuser) begin
        offset_d   = 8'd0;
        count_d    = 4'd0;
        remain_d   = 16'd0;
        rec_len_d  = 16'd0;
        selected_d = 1'b0;
        query_d    = s_axis_tdata[15:8];
        scan_d     = s_axis_tdata[23:16];
        phase_d    = tlvrs_pkg::PH_TAG;
        if (scan_d == tlvrs_pkg::SCAN_INVALID ||
            (query_d[7:4] == tlvrs_pkg::POS_MODE && query_d[3:0] == tlvrs_pkg::POS_NONE)) begin
          emit0   = 1'b1;
          phase_d = tlvrs_pkg::PH_IDLE;
          done    = 1'b1;
        end
      end
      pos_mode = query_d[7:4] == tlvrs_pkg::POS_MODE;

      if (!done && phase_d != tlvrs_pkg::PH_IDLE) begin
        unique case (phase_d)
          tlvrs_pkg::PH_TAG: begin
            if (pos_mode) begin
              if (count_d != tlvrs_pkg::COUNT_MAX) begin
                count_d = count_d + 4'd1;
              end
              selected_d = count_d == query_d[3:0];
            end else begin
              selected_d = in_byte[6:0] == query_d[6:0];
            end
            rec_len_d = 16'd0;
            phase_d   = tlvrs_pkg::PH_LEN;
            // in tag mode, a tag at or beyond the scan limit ends the search
            if (!pos_mode && offset_d >= scan_d) begin
              emit0   = 1'b1;
              phase_d = tlvrs_pkg::PH_IDLE;
              done    = 1'b1;
            end
          end
          tlvrs_pkg::PH_LEN: begin
            if (in_byte == tlvrs_pkg::LEN_ONE_BYTE) begin
              rec_len_d = 16'd0;
              phase_d   = tlvrs_pkg::PH_LEN_LO;
            end else if (in_byte == tlvrs_pkg::LEN_TWO_BYTES) begin
              phase_d = tlvrs_pkg::PH_LEN_HI;
            end else begin
              rec_len_d = {8'd0, in_byte};
            end
          end
          tlvrs_pkg::PH_LEN_HI: begin
            rec_len_d = {in_byte, 8'd0};
            phase_d   = tlvrs_pkg::PH_LEN_LO;
          end
          tlvrs_pkg::PH_LEN_LO: begin
            rec_len_d = {rec_len_d[15:8], in_byte};
          end
          tlvrs_pkg::PH_VALUE: begin
            if (selected_d) begin
              emit0 = 1'b1;
              r0    = '{value_length: 16'd0, kind: tlvrs_pkg::KIND_BYTE, out_byte: in_byte};
            end
            remain_d = remain_d - 16'd1;
            if (remain_d == 16'd0) begin
              if (selected_d) begin
                emit1   = 1'b1;
                r1      = '{value_length: rec_len_d, kind: tlvrs_pkg::KIND_DONE,
                            out_byte: 8'd0};
                phase_d = tlvrs_pkg::PH_IDLE;
              end else begin
                phase_d = tlvrs_pkg::PH_TAG;
              end
            end
          end
          default: phase_d = tlvrs_pkg::PH_IDLE;
        endcase

        // header complete: short form length or final long-form length byte
        if (!done && !s_axis_tuser && (phase_q == tlvrs_pkg::PH_LEN_LO ||
            (phase_q == tlvrs_pkg::PH_LEN &&
             in_byte != tlvrs_pkg::LEN_ONE_BYTE && in_byte != tlvrs_pkg::LEN_TWO_BYTES))) begin
          remain_d = rec_len_d;
          if (remain_d != 16'd0) begin
            phase_d = tlvrs_pkg::PH_VALUE;
          end else if (selected_d) begin
            emit0   = 1'b1;
            r0      = '{value_length: 16'd0, kind: tlvrs_pkg::KIND_DONE, out_byte: 8'd0};
            phase_d = tlvrs_pkg::PH_IDLE;
          end else begin
            phase_d = tlvrs_pkg::PH_TAG;
          end
        end

        if (!done) begin
          if (offset_d != tlvrs_pkg::OFFSET_MAX) begin
            offset_d = offset_d + 8'd1;
          end
          // stream ended before the search was decided
          if (phase_d != tlvrs_pkg::PH_IDLE && s_axis_tlast) begin
            phase_d = tlvrs_pkg::PH_IDLE;
            if (emit0) begin
              emit1 = 1'b1;
              r1    = '{value_length: 16'd0, kind: tlvrs_pkg::KIND_NONE, out_byte: 8'd0};
            end else begin
              emit0 = 1'b1;
              r0    = '{value_length: 16'd0, kind: tlvrs_pkg::KIND_NONE, out_byte: 8'd0};
            end
          end
        end
      end
    end

    // compact so the first result always goes into slot 0
    if (!emit0 && emit1) begin
      push0 = 1'b1;
      push1 = 1'b0;
      res0  = r1;
    end else begin
      push0 = emit0;
      push1 = emit1;
      res0  = r0;
    end
    res1 = r1;
  end

  // phase_d starts from phase_q, and the header-complete check reads phase_q;
  // that check is gated off on a first byte, which restarts the parse in PH_TAG
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= tlvrs_pkg::PH_IDLE;
      offset_q   <= 8'd0;
      count_q    <= 4'd0;
      remain_q   <= 16'd0;
      rec_len_q  <= 16'd0;
      selected_q <= 1'b0;
      query_q    <= 8'd0;
      scan_q     <= 8'd0;
    end else begin
      phase_q    <= phase_d;
      offset_q   <= offset_d;
      count_q    <= count_d;
      remain_q   <= remain_d;
      rec_len_q  <= rec_len_d;
      selected_q <= selected_d;
      query_q    <= query_d;
      scan_q     <= scan_d;
    end
  end

  // result queue
  always_comb begin
    fill_d = fill_q;
    if (push0 && push1) begin
      fill_d = fill_d + CntW'(2);
    end else if (push0) begin
      fill_d = fill_d + CntW'(1);
    end
    if (out_acc) begin
      fill_d = fill_d - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push0 && push1) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(2);
      end else if (push0) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0) begin
      res_mem_q[wr_ptr_q] <= res0;
    end
    if (push1) begin
      res_mem_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  assign m_axis_tvalid = fill_q != '0;
  assign m_axis_tdata  = {res_mem_q[rd_ptr_q].value_length, res_mem_q[rd_ptr_q].out_byte};
  assign m_axis_tuser  = res_mem_q[rd_ptr_q].kind;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(tlvrs_pkg::RES_DEPTH))
    else $error("result queue overfilled");

  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !s_axis_tuser && phase_q == tlvrs_pkg::PH_IDLE) |-> !push0)
    else $error("result produced outside a search");

  a_marker_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != tlvrs_pkg::KIND_BYTE) |-> m_axis_tdata[7:0] == 8'd0)
    else $error("done or not-found result carries a data byte");

  a_search_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push0 && res0.kind != tlvrs_pkg::KIND_BYTE) |=> phase_q == tlvrs_pkg::PH_IDLE)
    else $error("search continues after its final result");
`endif

endmodule

// ----- verif/tlv_record_search_unit_tb.sv -----
`timescale 1ns / 1ps

module tlv_record_search_unit_tb;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned PHASE_ITEMS = 225;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] query;
    logic [7:0] scan;
    logic       first;
    logic       last;
  } tlv_byte_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // in_byte[7:0], query_tag[15:8], scan_length[23:16]
  logic        s_axis_tuser = 1'b0; // first_byte
  logic        s_axis_tlast = 1'b0; // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // out_byte[7:0], value_length[23:8]
  logic [1:0]  m_axis_tuser;        // kind

  tlv_record_search_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  tlv_byte_t            tlv_bytes[$];
  tlv_byte_t            draft[$];
  tlvrs_pkg::result_t   pending_results[$];
  tlv_byte_t            drv_byte;
  tlvrs_pkg::result_t   want_res;
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_stall_pct = 0;
  int unsigned          staged_count;
  int unsigned          mismatch_cnt = 0;
  int unsigned          idle_cycles = 0;

  // search tracker state
  tlvrs_pkg::phase_e trk_phase = tlvrs_pkg::PH_IDLE;
  logic [7:0]  trk_offset = '0;
  logic [3:0]  trk_count = '0;
  logic [15:0] trk_remaining = '0;
  logic [15:0] trk_rec_len = '0;
  logic        trk_selected = 1'b0;
  logic [7:0]  trk_query = '0;
  logic [7:0]  trk_scan = '0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic emit(input logic [7:0] b, input tlvrs_pkg::kind_e k,
                      input logic [15:0] len);
    tlvrs_pkg::result_t r;
    r.out_byte     = b;
    r.kind         = k;
    r.value_length = len;
    pending_results.push_back(r);
  endtask

  task automatic end_of_header();
    trk_remaining = trk_rec_len;
    if (trk_remaining != 16'd0) begin
      trk_phase = tlvrs_pkg::PH_VALUE;
    end else if (trk_selected) begin
      emit(8'h00, tlvrs_pkg::KIND_DONE, 16'd0);
      trk_phase = tlvrs_pkg::PH_IDLE;
    end else begin
      trk_phase = tlvrs_pkg::PH_TAG;
    end
  endtask

  // advance the search by one accepted byte, queueing the results it yields
  task automatic search_step(input tlv_byte_t t);
    logic pos_mode;
    if (t.first) begin
      trk_offset    = '0;
      trk_count     = '0;
      trk_remaining = '0;
      trk_rec_len   = '0;
      trk_selected  = 1'b0;
      trk_query     = t.query;
      trk_scan      = t.scan;
      trk_phase     = tlvrs_pkg::PH_TAG;
      if (trk_scan == tlvrs_pkg::SCAN_INVALID ||
          (trk_query[7:4] == tlvrs_pkg::POS_MODE &&
           trk_query[3:0] == tlvrs_pkg::POS_NONE)) begin
        emit(8'h00, tlvrs_pkg::KIND_NONE, 16'd0);
        trk_phase = tlvrs_pkg::PH_IDLE;
        return;
      end
    end
    if (trk_phase == tlvrs_pkg::PH_IDLE) return;
    pos_mode = (trk_query[7:4] == tlvrs_pkg::POS_MODE);
    case (trk_phase)
      tlvrs_pkg::PH_TAG: begin
        if (pos_mode) begin
          if (trk_count != tlvrs_pkg::COUNT_MAX) trk_count++;
          trk_selected = (trk_count == trk_query[3:0]);
        end else begin
          if (trk_offset >= trk_scan) begin
            emit(8'h00, tlvrs_pkg::KIND_NONE, 16'd0);
            trk_phase = tlvrs_pkg::PH_IDLE;
            return;
          end
          trk_selected = (t.data[6:0] == trk_query[6:0]);
        end
        trk_rec_len = '0;
        trk_phase   = tlvrs_pkg::PH_LEN;
      end
      tlvrs_pkg::PH_LEN: begin
        if (t.data == tlvrs_pkg::LEN_ONE_BYTE) begin
          trk_rec_len = '0;
          trk_phase   = tlvrs_pkg::PH_LEN_LO;
        end else if (t.data == tlvrs_pkg::LEN_TWO_BYTES) begin
          trk_phase = tlvrs_pkg::PH_LEN_HI;
        end else begin
          trk_rec_len = {8'h00, t.data};
          end_of_header();
        end
      end
      tlvrs_pkg::PH_LEN_HI: begin
        trk_rec_len = {t.data, 8'h00};
        trk_phase   = tlvrs_pkg::PH_LEN_LO;
      end
      tlvrs_pkg::PH_LEN_LO: begin
        trk_rec_len = {trk_rec_len[15:8], t.data};
        end_of_header();
      end
      tlvrs_pkg::PH_VALUE: begin
        if (trk_selected) emit(t.data, tlvrs_pkg::KIND_BYTE, 16'd0);
        trk_remaining = trk_remaining - 16'd1;
        if (trk_remaining == 16'd0) begin
          if (trk_selected) begin
            emit(8'h00, tlvrs_pkg::KIND_DONE, trk_rec_len);
            trk_phase = tlvrs_pkg::PH_IDLE;
          end else begin
            trk_phase = tlvrs_pkg::PH_TAG;
          end
        end
      end
      default: trk_phase = tlvrs_pkg::PH_IDLE;
    endcase
    if (trk_offset != tlvrs_pkg::OFFSET_MAX) trk_offset++;
    if (trk_phase != tlvrs_pkg::PH_IDLE && t.last) begin
      emit(8'h00, tlvrs_pkg::KIND_NONE, 16'd0);
      trk_phase = tlvrs_pkg::PH_IDLE;
    end
  endtask

  task automatic put(input logic [7:0] b, input logic first, input logic last,
                     input logic [7:0] q, input logic [7:0] s);
    tlv_byte_t t;
    t.data  = b;
    t.first = first;
    t.last  = last;
    t.query = q;
    t.scan  = s;
    tlv_bytes.push_back(t);
  endtask

  // query and scan fields of non-first bytes are don't-care, so randomize them
  task automatic stage(input logic [7:0] b);
    tlv_byte_t t;
    t.data  = b;
    t.first = 1'b0;
    t.last  = 1'b0;
    t.query = 8'($urandom);
    t.scan  = 8'($urandom);
    draft.push_back(t);
  endtask

  task automatic add_search();
    logic [7:0]  q;
    logic [7:0]  s;
    logic [7:0]  tag;
    int unsigned nrec;
    int unsigned vlen;
    int unsigned cut;
    int unsigned roll;
    tlv_byte_t   t;
    draft.delete();
    roll = $urandom_range(99);
    if (roll < 45) q = {tlvrs_pkg::POS_MODE, 4'($urandom_range(15))};
    else q = 8'($urandom);
    roll = $urandom_range(99);
    if (roll < 5) s = tlvrs_pkg::SCAN_INVALID;
    else if (roll < 10) s = 8'h00;
    else if (roll < 40) s = 8'($urandom_range(20, 1));
    else s = 8'($urandom_range(254, 21));
    nrec = ($urandom_range(19) == 0) ? $urandom_range(17, 10) : $urandom_range(5, 1);
    for (int r = 0; r < nrec; r++) begin
      tag = 8'($urandom);
      if ($urandom_range(2) == 0) tag[6:0] = q[6:0];
      stage(tag);
      // rare long records push the offset into saturation
      vlen = ($urandom_range(99) < 2) ? $urandom_range(300, 131) : $urandom_range(6);
      roll = $urandom_range(2);
      if (roll == 0 && vlen < 256 && vlen != 32'(tlvrs_pkg::LEN_ONE_BYTE) &&
          vlen != 32'(tlvrs_pkg::LEN_TWO_BYTES)) begin
        stage(8'(vlen));
      end else if (roll == 1 && vlen < 256) begin
        stage(tlvrs_pkg::LEN_ONE_BYTE);
        stage(8'(vlen));
      end else begin
        stage(tlvrs_pkg::LEN_TWO_BYTES);
        stage(8'(vlen >> 8));
        stage(8'(vlen));
      end
      for (int v = 0; v < vlen; v++) stage(8'($urandom));
    end
    cut = draft.size();
    if ($urandom_range(99) < 15) cut = $urandom_range(draft.size(), 1);
    while (draft.size() > cut) void'(draft.pop_back());
    draft[0].first = 1'b1;
    draft[0].query = q;
    draft[0].scan  = s;
    if ($urandom_range(99) >= 10) draft[$].last = 1'b1;
    staged_count += draft.size();
    foreach (draft[i]) tlv_bytes.push_back(draft[i]);
    if ($urandom_range(4) == 0) begin
      for (int k = $urandom_range(3, 1); k > 0; k--) begin
        t.data  = 8'($urandom);
        t.first = 1'b0;
        t.last  = 1'($urandom);
        t.query = 8'($urandom);
        t.scan  = 8'($urandom);
        tlv_bytes.push_back(t);
      end
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      s_axis_tlast  <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tlv_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_byte = tlv_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {drv_byte.scan, drv_byte.query, drv_byte.data};
        s_axis_tuser  <= drv_byte.first;
        s_axis_tlast  <= drv_byte.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: track accepted input bytes, check accepted results in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        search_step({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                     s_axis_tuser, s_axis_tlast});
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result: byte %h kind %0d len %0d", $time,
                   m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[23:8]);
        end else begin
          want_res = pending_results.pop_front();
          if (m_axis_tdata[7:0] !== want_res.out_byte ||
              m_axis_tuser !== want_res.kind ||
              m_axis_tdata[23:8] !== want_res.value_length) begin
            mismatch_cnt++;
            $display("%0t: expected byte %h kind %0d len %0d, got byte %h kind %0d len %0d",
                     $time, want_res.out_byte, want_res.kind, want_res.value_length,
                     m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[23:8]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tlv_record_search_unit_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: ignored byte, invalid scan, stray byte after a result,
    // position zero, scan limit of zero
    put(8'hA5, 1'b0, 1'b0, 8'hFF, 8'hFF);
    put(8'h12, 1'b1, 1'b0, 8'h12, tlvrs_pkg::SCAN_INVALID);
    put(8'h34, 1'b0, 1'b0, 8'h00, 8'h00);
    put(8'h01, 1'b1, 1'b0, {tlvrs_pkg::POS_MODE, tlvrs_pkg::POS_NONE}, 8'h10);
    put(8'h00, 1'b1, 1'b0, 8'h00, 8'h00);
    // tag match ignoring bit 7, empty value
    put(8'h05, 1'b1, 1'b0, 8'h85, 8'hFE);
    put(8'h00, 1'b0, 1'b0, 8'hFF, 8'hFF);
    // second record by position, one-byte-extended length
    put(8'hFF, 1'b1, 1'b0, {tlvrs_pkg::POS_MODE, 4'h2}, 8'h10);
    put(8'h01, 1'b0, 1'b0, 8'h00, 8'h00);
    put(8'h7F, 1'b0, 1'b0, 8'hFF, 8'hFF);
    put(8'h80, 1'b0, 1'b0, 8'h00, 8'h00);
    put(tlvrs_pkg::LEN_ONE_BYTE, 1'b0, 1'b0, 8'hFF, 8'hFF);
    put(8'h02, 1'b0, 1'b0, 8'h00, 8'h00);
    put(8'h00, 1'b0, 1'b0, 8'hFF, 8'hFF);
    put(8'hFF, 1'b0, 1'b1, 8'h00, 8'h00);
    // two-byte length, record cut off by end of buffer
    put(8'hBC, 1'b1, 1'b0, 8'h3C, 8'hFE);
    put(tlvrs_pkg::LEN_TWO_BYTES, 1'b0, 1'b0, 8'h00, 8'h00);
    put(8'h00, 1'b0, 1'b0, 8'hFF, 8'hFF);
    put(8'h03, 1'b0, 1'b0, 8'h00, 8'h00);
    put(8'hAA, 1'b0, 1'b0, 8'hFF, 8'hFF);
    put(8'h55, 1'b0, 1'b1, 8'h00, 8'h00);
    // buffer of a single byte
    put(8'h3C, 1'b1, 1'b1, 8'h3C, 8'h20);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      staged_count = 0;
      while (staged_count < PHASE_ITEMS) add_search();
      while (tlv_bytes.size() != 0) @(negedge clk_i);
    end

    while (pending_results.size() != 0 || tlv_bytes.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("tlv_record_search_unit_tb OK");
    end else begin
      $display("tlv_record_search_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tlvrs_pkg.sv
hdl/tlv_record_search_unit.sv
verif/tlv_record_search_unit_tb.sv
